// File: rtl/memory_watchpoint_table_macros.svh
// Assertion shorthands for the watchpoint table
`ifndef MEMORY_WATCHPOINT_TABLE_MACROS_SVH
`define MEMORY_WATCHPOINT_TABLE_MACROS_SVH

// Hold at every edge outside reset
`define MWT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define MWT_IMPLIES(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication
`define MWT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: rtl/mwt_pkg.sv
package mwt_pkg;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [2:0] {
        KIND_ADD    = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_CLEAR  = 3'd2,
        KIND_ACCESS = 3'd3,
        KIND_PAGE   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    typedef struct packed {
        logic ranged;
        logic brk;
        logic log;
        logic wr;
        logic rd;
    } flags_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] end_addr;
        flags_t            flags;
    } entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W:0]   hi;
        logic [ADDR_W-1:0] pend;
        logic [ADDR_W-1:0] suffix;
        logic              is_write;
    } query_t;

    typedef struct packed {
        logic covered;
        logic key;
        logic access;
        logic dir_log;
        logic dir_brk;
        logic page;
    } hit_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

// File: rtl/memory_watchpoint_table.sv
// Memory watchpoint table: an ordered row of up to ENTRIES address-range
// watchpoints, one per cell, compared against each incoming item.
// Input channel: item_valid / item_stall carry kind and the item fields
// (add, remove, clear, access check, page overlap query).
// Output channel: result_valid / result_stall carry one result per item
// (status, matched, log_hit, break_hit, overlap, flush_translation, count_now).
// Steps: the item is registered on acceptance; in S_CMP the cells compare
// the registered item and their hits are registered; in S_RES the first
// hit is resolved and the cells and the entry count updated.
// Only one item is at work at a time; item_stall is high while an item
// is at work. A remove closes the gap by moving each later cell's entry
// one place down, all at once in S_RES.
// A finished result waits in the output register; a further item is taken
// meanwhile and holds in S_RES until result_stall falls.
// Reset empties the table (entry count zero) and clears result_valid;
// cell contents need no reset as only entries below the count are read.
module memory_watchpoint_table #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] address,
    input  logic [31:0] range_end,
    input  logic        ranged,
    input  logic        watch_read,
    input  logic        watch_write,
    input  logic        log_enable,
    input  logic        break_enable,
    input  logic [3:0]  access_bytes,
    input  logic        is_write,
    input  logic [4:0]  page_shift,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic        matched,
    output logic        log_hit,
    output logic        break_hit,
    output logic        overlap,
    output logic        flush_translation,
    output logic [4:0]  count_now
);
    import mwt_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_RES  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    kind_t             kind_reg;
    query_t            query_reg;
    entry_t            new_reg;

    logic [ENTRIES-1:0] cov_reg, key_reg, acc_reg, dlog_reg, dbrk_reg, page_reg;
    logic [ENTRIES-1:0] vld, cov_v, key_v, acc_v, page_v;
    logic [ENTRIES-1:0] acc_first, key_first, ge_mask, load_vec;

    entry_t    entries   [ENTRIES];
    hit_t      hits      [ENTRIES];
    cell_ctl_t ctls      [ENTRIES];

    logic              res_fire;
    logic              add_ok, rm_ok;
    logic              result_valid_reg;
    status_t           status_next;
    logic              matched_next, log_next, brk_next, overlap_next, flush_next;
    logic [1:0]        status_reg;
    logic              matched_reg, log_reg, brk_reg, overlap_reg, flush_reg;
    logic [COUNT_W-1:0] count_now_reg;

    logic [3:0]        len;
    logic [ADDR_W-1:0] suffix;

    assign item_stall = (state_reg != S_IDLE);
    assign res_fire   = (state_reg == S_RES) && (!result_valid_reg || !result_stall);

    // capture item
    always_comb
    begin
        len    = (access_bytes == 4'd0) ? 4'd1 : access_bytes;
        suffix = ADDR_W'((33'd1 << page_shift) - 33'd1);
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            kind_reg           <= kind_t'(kind);
            query_reg.addr     <= address;
            query_reg.hi       <= {1'b0, address} + (ADDR_W + 1)'(len)
                                  - (ADDR_W + 1)'(1);
            query_reg.suffix   <= suffix;
            query_reg.pend     <= address | suffix;
            query_reg.is_write <= is_write;
            new_reg.start      <= address;
            new_reg.end_addr   <= ranged ? range_end : address;
            new_reg.flags      <= '{ranged: ranged, brk: break_enable, log: log_enable,
                                    wr: watch_write, rd: watch_read};
        end
        if (state_reg == S_CMP)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                cov_reg[i]  <= hits[i].covered;
                key_reg[i]  <= hits[i].key;
                acc_reg[i]  <= hits[i].access;
                dlog_reg[i] <= hits[i].dir_log;
                dbrk_reg[i] <= hits[i].dir_brk;
                page_reg[i] <= hits[i].page;
            end
        end
    end

    // cell row
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        assign vld[g]      = (CW'(g) < count_reg);
        assign load_vec[g] = res_fire && add_ok && (count_reg == CW'(g));
        assign ctls[g]     = '{load: load_vec[g], shift: res_fire && rm_ok && ge_mask[g]};

        mwt_cell u_cell (
            .clk        (clk),
            .ctl        (ctls[g]),
            .new_entry  (new_reg),
            .next_entry (entries[(g + 1 < ENTRIES) ? g + 1 : g]),
            .query      (query_reg),
            .entry      (entries[g]),
            .hits       (hits[g])
        );
    end

    // resolve
    always_comb
    begin
        cov_v     = cov_reg & vld;
        key_v     = key_reg & vld;
        acc_v     = acc_reg & vld;
        page_v    = page_reg & vld;
        acc_first = acc_v & (~acc_v + ENTRIES'(1));
        key_first = key_v & (~key_v + ENTRIES'(1));
        ge_mask   = ~(key_first - ENTRIES'(1));

        add_ok       = 1'b0;
        rm_ok        = 1'b0;
        count_next   = count_reg;
        status_next  = ST_DONE;
        matched_next = 1'b0;
        log_next     = 1'b0;
        brk_next     = 1'b0;
        overlap_next = 1'b0;
        flush_next   = 1'b0;

        case (kind_reg)
            KIND_ADD:
            begin
                if (|cov_v)
                begin
                    status_next = ST_DUP;
                end
                else if (count_reg == CW'(ENTRIES))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    add_ok     = 1'b1;
                    count_next = count_reg + CW'(1);
                    flush_next = (count_reg == '0);
                end
            end
            KIND_REMOVE:
            begin
                if (|key_v)
                begin
                    rm_ok      = 1'b1;
                    count_next = count_reg - CW'(1);
                    flush_next = (count_reg == CW'(1));
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            KIND_CLEAR:
            begin
                count_next = '0;
                flush_next = 1'b1;
            end
            KIND_ACCESS:
            begin
                matched_next = |acc_v;
                log_next     = |(acc_first & dlog_reg);
                brk_next     = |(acc_first & dbrk_reg);
            end
            KIND_PAGE:
            begin
                overlap_next = |page_v;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_RES;
            end
            S_RES:
            begin
                if (res_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_fire)
            begin
                count_reg        <= count_next;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            status_reg    <= status_next;
            matched_reg   <= matched_next;
            log_reg       <= log_next;
            brk_reg       <= brk_next;
            overlap_reg   <= overlap_next;
            flush_reg     <= flush_next;
            count_now_reg <= COUNT_W'(count_next);
        end
    end

    assign result_valid      = result_valid_reg;
    assign status            = status_reg;
    assign matched           = matched_reg;
    assign log_hit           = log_reg;
    assign break_hit         = brk_reg;
    assign overlap           = overlap_reg;
    assign flush_translation = flush_reg;
    assign count_now         = count_now_reg;

`include "memory_watchpoint_table_macros.svh"

    `MWT_HOLDS(a_count_bound, count_reg <= CW'(ENTRIES), "entry count beyond table depth")
    `MWT_HOLDS(a_single_load, $onehot0(load_vec), "more than one cell loaded")
    `MWT_NEXT(a_clear_empties, res_fire && kind_reg == KIND_CLEAR,
        count_reg == '0 && result_valid && flush_translation,
        "clear did not empty the table")
    `MWT_IMPLIES(a_flush_small, result_valid && flush_translation,
        count_now <= 5'd1, "flush with more than one entry")

endmodule

// File: rtl/mwt_cell.sv
module mwt_cell (
    input  logic               clk,
    input  mwt_pkg::cell_ctl_t ctl,
    input  mwt_pkg::entry_t    new_entry,
    input  mwt_pkg::entry_t    next_entry,
    input  mwt_pkg::query_t    query,
    output mwt_pkg::entry_t    entry,
    output mwt_pkg::hit_t      hits
);
    import mwt_pkg::*;

    entry_t            entry_reg;
    logic [ADDR_W-1:0] s_pg;
    logic [ADDR_W-1:0] e_pg;
    logic              dir;

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            entry_reg <= new_entry;
        end
        else if (ctl.shift)
        begin
            entry_reg <= next_entry;
        end
    end

    always_comb
    begin
        s_pg = entry_reg.start | query.suffix;
        e_pg = entry_reg.end_addr | query.suffix;
        dir  = query.is_write ? entry_reg.flags.wr : entry_reg.flags.rd;
        hits.covered = (entry_reg.end_addr >= query.addr)
                       && (query.addr >= entry_reg.start);
        hits.key     = (entry_reg.start == query.addr);
        hits.access  = ({1'b0, entry_reg.end_addr} >= {1'b0, query.addr})
                       && (query.hi >= {1'b0, entry_reg.start});
        hits.dir_log = dir && entry_reg.flags.log;
        hits.dir_brk = dir && entry_reg.flags.brk;
        hits.page    = (s_pg == query.pend) || (e_pg == query.pend)
                       || ((s_pg < query.pend) && (e_pg > query.pend));
    end

    assign entry = entry_reg;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mwt_pkg::*;

    localparam int ENTRIES = 16;
    localparam int RANDOM_ITEMS = 850;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] address;
        logic [31:0] range_end;
        logic        ranged;
        logic        watch_read;
        logic        watch_write;
        logic        log_enable;
        logic        break_enable;
        logic [3:0]  access_bytes;
        logic        is_write;
        logic [4:0]  page_shift;
    } watch_item_t;

    typedef struct packed {
        status_t    status;
        logic       matched;
        logic       log_hit;
        logic       break_hit;
        logic       overlap;
        logic       flush;
        logic [4:0] count;
    } watch_result_t;

    typedef struct packed {
        watch_item_t   item;
        logic          typed;
        watch_result_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [2:0]  kind;
    logic [31:0] address;
    logic [31:0] range_end;
    logic        ranged;
    logic        watch_read;
    logic        watch_write;
    logic        log_enable;
    logic        break_enable;
    logic [3:0]  access_bytes;
    logic        is_write;
    logic [4:0]  page_shift;
    logic        result_valid;
    logic        result_stall;
    logic [1:0]  status;
    logic        matched;
    logic        log_hit;
    logic        break_hit;
    logic        overlap;
    logic        flush_translation;
    logic [4:0]  count_now;

    entry_t        shadow_entries [ENTRIES];
    int            shadow_count;
    watch_result_t pending_results [$];
    int            mismatches;
    int            send_mode;
    int            recv_mode;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{KIND_ACCESS, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd8, 1'b0, 5'd0},
          1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0}},
        '{'{KIND_PAGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
            4'd15, 1'b1, 5'd31},
          1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0}},
        '{'{KIND_CLEAR, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd0, 1'b0, 5'd0},
          1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 5'd0}},
        '{'{KIND_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd0, 1'b0, 5'd0},
          1'b1, '{ST_MISS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0}},
        '{'{KIND_ADD, 32'h0000_1000, 32'h0000_10FF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
            4'd0, 1'b0, 5'd0},
          1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 5'd1}},
        '{'{KIND_ADD, 32'h0000_1080, 32'h0000_2000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
            4'd0, 1'b0, 5'd0},
          1'b1, '{ST_DUP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd1}},
        '{'{KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
            4'd0, 1'b0, 5'd0},
          1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd2}},
        '{'{KIND_ADD, 32'h0000_8000, 32'h0000_7000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
            4'd0, 1'b0, 5'd0},
          1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd3}},
        '{'{KIND_ADD, 32'h0000_8000, 32'h0000_8010, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1,
            4'd0, 1'b0, 5'd0}, 1'b0, '0},
        '{'{KIND_ADD, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
            4'd0, 1'b0, 5'd0}, 1'b0, '0},
        '{'{KIND_ACCESS, 32'hFFFF_FFF8, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd8, 1'b1, 5'd0}, 1'b0, '0},
        '{'{KIND_ACCESS, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd8, 1'b0, 5'd0}, 1'b0, '0},
        '{'{KIND_ACCESS, 32'h0000_10FE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd4, 1'b0, 5'd0}, 1'b0, '0},
        '{'{KIND_ACCESS, 32'h0000_7800, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd0, 1'b0, 5'd0}, 1'b0, '0},
        '{'{KIND_ACCESS, 32'h0000_8008, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd2, 1'b1, 5'd0}, 1'b0, '0},
        '{'{KIND_PAGE, 32'h0000_7000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd0, 1'b0, 5'd12}, 1'b0, '0},
        '{'{KIND_PAGE, 32'h0000_2000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd0, 1'b0, 5'd0}, 1'b0, '0},
        '{'{3'd5, 32'h0000_1000, 32'h0000_1000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
            4'd1, 1'b0, 5'd3}, 1'b0, '0},
        '{'{KIND_REMOVE, 32'h0000_8000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd0, 1'b0, 5'd0}, 1'b0, '0},
        '{'{3'd7, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd8, 1'b1, 5'd31}, 1'b0, '0},
        '{'{KIND_CLEAR, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd0, 1'b0, 5'd0},
          1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 5'd0}},
        '{'{KIND_ADD, 32'h0000_0040, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
            4'd0, 1'b0, 5'd0},
          1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 5'd1}},
        '{'{KIND_REMOVE, 32'h0000_0040, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            4'd0, 1'b0, 5'd0},
          1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 5'd0}},
        '{'{3'd6, 32'h0000_0040, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
            4'd8, 1'b0, 5'd16},
          1'b1, '{ST_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0}}
    };

    memory_watchpoint_table #(
        .ENTRIES (ENTRIES)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .kind              (kind),
        .address           (address),
        .range_end         (range_end),
        .ranged            (ranged),
        .watch_read        (watch_read),
        .watch_write       (watch_write),
        .log_enable        (log_enable),
        .break_enable      (break_enable),
        .access_bytes      (access_bytes),
        .is_write          (is_write),
        .page_shift        (page_shift),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .status            (status),
        .matched           (matched),
        .log_hit           (log_hit),
        .break_hit         (break_hit),
        .overlap           (overlap),
        .flush_translation (flush_translation),
        .count_now         (count_now)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int draw_gap(input int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 2);
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    function automatic int first_overlap(input logic [32:0] lo, input logic [32:0] hi);
        for (int i = 0; i < shadow_count; i++)
        begin
            if ({1'b0, shadow_entries[i].end_addr} >= lo
                && hi >= {1'b0, shadow_entries[i].start})
                return i;
        end
        return -1;
    endfunction

    function automatic watch_result_t predict_watch(input watch_item_t it);
        watch_result_t r;
        logic [32:0]   hi;
        logic [31:0]   suffix;
        logic [31:0]   pend;
        logic [31:0]   s;
        logic [31:0]   e;
        flags_t        f;
        logic          dir;
        int            idx;
        r = '0;
        case (it.kind)
            KIND_ADD:
            begin
                if (first_overlap({1'b0, it.address}, {1'b0, it.address}) >= 0)
                    r.status = ST_DUP;
                else if (shadow_count >= ENTRIES)
                    r.status = ST_FULL;
                else
                begin
                    f.ranged = it.ranged;
                    f.brk = it.break_enable;
                    f.log = it.log_enable;
                    f.wr = it.watch_write;
                    f.rd = it.watch_read;
                    shadow_entries[shadow_count].start = it.address;
                    shadow_entries[shadow_count].end_addr = it.ranged ? it.range_end : it.address;
                    shadow_entries[shadow_count].flags = f;
                    r.flush = (shadow_count == 0);
                    shadow_count++;
                end
            end
            KIND_REMOVE:
            begin
                idx = -1;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (idx < 0 && shadow_entries[i].start == it.address)
                        idx = i;
                end
                if (idx < 0)
                    r.status = ST_MISS;
                else
                begin
                    for (int i = idx; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_count--;
                    r.flush = (shadow_count == 0);
                end
            end
            KIND_CLEAR:
            begin
                shadow_count = 0;
                r.flush = 1'b1;
            end
            KIND_ACCESS:
            begin
                hi = {1'b0, it.address} + ((it.access_bytes == 4'd0) ? 33'd1 : 33'(it.access_bytes))
                     - 33'd1;
                idx = first_overlap({1'b0, it.address}, hi);
                if (idx >= 0)
                begin
                    f = shadow_entries[idx].flags;
                    dir = it.is_write ? f.wr : f.rd;
                    r.matched = 1'b1;
                    r.log_hit = dir & f.log;
                    r.break_hit = dir & f.brk;
                end
            end
            KIND_PAGE:
            begin
                suffix = 32'((64'd1 << it.page_shift) - 64'd1);
                pend = it.address | suffix;
                for (int i = 0; i < shadow_count; i++)
                begin
                    s = shadow_entries[i].start | suffix;
                    e = shadow_entries[i].end_addr | suffix;
                    if (s == pend || e == pend || (s < pend && e > pend))
                        r.overlap = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.count = 5'(shadow_count);
        return r;
    endfunction

    function automatic logic [31:0] pick_address();
        case ($urandom_range(0, 9))
            0, 1: return 32'h0000_0000 + $urandom_range(0, 255);
            2: return 32'h0000_1000 + $urandom_range(0, 255);
            3: return 32'h8000_0000 + $urandom_range(0, 255);
            4, 5: return 32'hFFFF_FF00 + $urandom_range(0, 255);
            6, 7:
            begin
                if (shadow_count > 0)
                    return shadow_entries[$urandom_range(0, shadow_count - 1)].end_addr
                           + $urandom_range(0, 2) - 1;
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic watch_item_t random_watch_item(input logic [2:0] op);
        watch_item_t it;
        it.kind = op;
        it.address = pick_address();
        case ($urandom_range(0, 5))
            0: it.range_end = it.address - 32'd1 - $urandom_range(0, 255);
            1: it.range_end = $urandom;
            default: it.range_end = it.address + $urandom_range(0, 96);
        endcase
        it.ranged = 1'($urandom_range(0, 1));
        it.watch_read = 1'($urandom_range(0, 1));
        it.watch_write = 1'($urandom_range(0, 1));
        it.log_enable = 1'($urandom_range(0, 1));
        it.break_enable = 1'($urandom_range(0, 1));
        it.access_bytes = 4'($urandom_range(0, 8));
        it.is_write = 1'($urandom_range(0, 1));
        it.page_shift = 5'($urandom_range(0, 31));
        if (op == KIND_REMOVE && shadow_count > 0 && $urandom_range(0, 9) < 7)
            it.address = shadow_entries[$urandom_range(0, shadow_count - 1)].start;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: %s got %0h, want %0h", $time, what, got, want);
    endtask

    task automatic issue_item(input watch_item_t it, input logic typed,
                              input watch_result_t typed_want);
        watch_result_t predicted;
        repeat (draw_gap(send_mode))
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        kind <= it.kind;
        address <= it.address;
        range_end <= it.range_end;
        ranged <= it.ranged;
        watch_read <= it.watch_read;
        watch_write <= it.watch_write;
        log_enable <= it.log_enable;
        break_enable <= it.break_enable;
        access_bytes <= it.access_bytes;
        is_write <= it.is_write;
        page_shift <= it.page_shift;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        predicted = predict_watch(it);
        pending_results = {pending_results, typed ? typed_want : predicted};
    endtask

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        watch_result_t want;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            repeat (draw_gap(recv_mode))
            begin
                @(negedge clk);
                result_stall <= 1'b1;
            end
            @(negedge clk);
            result_stall <= 1'b0;
            do @(posedge clk); while (result_valid !== 1'b1);
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", 32'd0, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (matched !== want.matched)
                    report_mismatch("matched", 32'(matched), 32'(want.matched));
                if (log_hit !== want.log_hit)
                    report_mismatch("log_hit", 32'(log_hit), 32'(want.log_hit));
                if (break_hit !== want.break_hit)
                    report_mismatch("break_hit", 32'(break_hit), 32'(want.break_hit));
                if (overlap !== want.overlap)
                    report_mismatch("overlap", 32'(overlap), 32'(want.overlap));
                if (flush_translation !== want.flush)
                    report_mismatch("flush_translation", 32'(flush_translation),
                                    32'(want.flush));
                if (count_now !== want.count)
                    report_mismatch("count_now", 32'(count_now), 32'(want.count));
            end
        end
    end

    initial
    begin
        watch_item_t it;
        logic [2:0]  op;
        logic [31:0] fill_base;
        int          sent;
        int          pick;
        rst_n = 1'b0;
        item_valid = 1'b0;
        kind = '0;
        address = '0;
        range_end = '0;
        ranged = 1'b0;
        watch_read = 1'b0;
        watch_write = 1'b0;
        log_enable = 1'b0;
        break_enable = 1'b0;
        access_bytes = '0;
        is_write = 1'b0;
        page_shift = '0;
        shadow_count = 0;
        mismatches = 0;
        send_mode = 2;
        recv_mode = 2;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            send_mode = $urandom_range(0, 2);
            recv_mode = $urandom_range(0, 2);
            // fill the table with disjoint ranges, running past full
            if ($urandom_range(0, 2) == 0)
            begin
                fill_base = $urandom & 32'hFFFF_F000;
                for (int i = 0; i < ENTRIES + 4; i++)
                begin
                    it = random_watch_item(KIND_ADD);
                    it.ranged = 1'b1;
                    it.address = fill_base + 32'(i * 64);
                    it.range_end = it.address + $urandom_range(0, 63);
                    issue_item(it, 1'b0, '0);
                    sent++;
                end
            end
            repeat (40)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    op = KIND_ADD;
                else if (pick < 45)
                    op = KIND_REMOVE;
                else if (pick < 48)
                    op = KIND_CLEAR;
                else if (pick < 80)
                    op = KIND_ACCESS;
                else if (pick < 97)
                    op = KIND_PAGE;
                else
                    op = 3'($urandom_range(5, 7));
                issue_item(random_watch_item(op), 1'b0, '0);
                if (op <= KIND_PAGE)
                    sent++;
            end
        end

        @(negedge clk);
        item_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
